>>> src/pcxrle_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the PCX run-length row decoder.
package pcxrle_pkg;

    localparam int DIM_W   = 13;  // width_pixels, height_rows, positions
    localparam int LINE_W  = 16;  // line_bytes and padding count
    localparam int CNT_W   = 6;   // run count
    localparam int POS_W   = 12;  // start_column and row_index fields
    localparam int FILL_W  = 13;  // zero_fill_count field
    localparam int INDEX_W = 2;   // configuration register index

    localparam logic [INDEX_W-1:0] REG_WIDTH_PIXELS = 2'd0;
    localparam logic [INDEX_W-1:0] REG_HEIGHT_ROWS  = 2'd1;
    localparam logic [INDEX_W-1:0] REG_LINE_BYTES   = 2'd2;

    localparam logic [7:0] RUN_HEADER_MIN = 8'hC0;
    localparam logic [7:0] RUN_COUNT_MASK = 8'h3F;
    localparam logic [7:0] ALPHA_INDEX    = 8'hFF;

    // effective image geometry, width and height after clamping
    typedef struct packed {
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [LINE_W-1:0] line_bytes;
    } geom_t;

    // one decoded run
    typedef struct packed {
        logic [7:0]        pixel_value;
        logic [CNT_W-1:0]  run_count;
        logic [POS_W-1:0]  start_column;
        logic [POS_W-1:0]  row_index;
        logic [FILL_W-1:0] zero_fill_count;
        logic              alpha_found;
        logic              image_done;
    } run_t;

endpackage

>>> src/pcxrle_if.sv
`timescale 1ns / 1ps
// Channel interfaces: compressed byte input, run output and register writes.
interface pcxrle_in_if
    import pcxrle_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface pcxrle_out_if
    import pcxrle_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [7:0]        pixel_value;
    logic [CNT_W-1:0]  run_count;
    logic [POS_W-1:0]  start_column;
    logic [POS_W-1:0]  row_index;
    logic [FILL_W-1:0] zero_fill_count;
    logic              alpha_found;
    logic              image_done;

    modport source (output valid, output pixel_value, output run_count,
                    output start_column, output row_index, output zero_fill_count,
                    output alpha_found, output image_done, input ready);
    modport sink   (input valid, input pixel_value, input run_count,
                    input start_column, input row_index, input zero_fill_count,
                    input alpha_found, input image_done, output ready);
endinterface

interface pcxrle_cfg_if
    import pcxrle_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] index;
    logic [LINE_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/pcxrle_cfg.sv
`timescale 1ns / 1ps
// Configuration registers with dimension clamping.
module pcxrle_cfg
    import pcxrle_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [INDEX_W-1:0] wr_index,
    input  logic [LINE_W-1:0] wr_data,
    output geom_t             geom
);

    // largest dimension allowed: MAX_DIM, capped at what the 13-bit registers can carry
    localparam int DIM_LIMIT = (MAX_DIM > (2 ** DIM_W) - 1) ? (2 ** DIM_W) - 1 : MAX_DIM;
    localparam logic [DIM_W-1:0] DIM_MAX = DIM_LIMIT[DIM_W-1:0];

    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [LINE_W-1:0] line_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            line_reg   <= LINE_W'(1);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_WIDTH_PIXELS: width_reg  <= wr_data[DIM_W-1:0];
                REG_HEIGHT_ROWS:  height_reg <= wr_data[DIM_W-1:0];
                REG_LINE_BYTES:   line_reg   <= wr_data;
                default:          ;
            endcase
        end
    end

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_MAX)
            r = DIM_MAX;
        else
            r = v;
        return r;
    endfunction

    always_comb
    begin
        geom.width      = clamp_dim(width_reg);
        geom.height     = clamp_dim(height_reg);
        geom.line_bytes = line_reg;
    end

endmodule

>>> src/pcxrle_core.sv
`timescale 1ns / 1ps
// Decode state and the single-pass step for one compressed byte.
module pcxrle_core
    import pcxrle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  geom_t      geom,
    input  logic       step,       // advance state with this byte
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       emit,       // this byte yields a run word
    output run_t       run
);

    logic [DIM_W-1:0]  column_reg, column_next;
    logic [DIM_W-1:0]  row_reg, row_next;
    logic              pending_reg, pending_next;
    logic [CNT_W-1:0]  pcount_reg, pcount_next;
    logic [LINE_W-1:0] pad_reg, pad_next;
    logic              alpha_reg, alpha_next;
    logic              finished_reg, finished_next;

    logic [DIM_W-1:0]  room;
    logic [DIM_W-1:0]  req_count;
    logic [DIM_W-1:0]  count;
    logic [DIM_W-1:0]  new_column;
    logic [DIM_W-1:0]  next_row;

    always_comb
    begin
        room       = (column_reg < geom.width) ? geom.width - column_reg : '0;
        req_count  = pending_reg ? DIM_W'(pcount_reg) : DIM_W'(1);
        count      = (req_count > room) ? room : req_count;
        new_column = column_reg + count;
        next_row   = row_reg + DIM_W'(1);

        column_next   = column_reg;
        row_next      = row_reg;
        pending_next  = pending_reg;
        pcount_next   = pcount_reg;
        pad_next      = pad_reg;
        alpha_next    = alpha_reg;
        finished_next = finished_reg;
        emit          = 1'b0;
        run           = '0;

        if (finished_reg)
        begin
            // drop everything until reset
        end
        else if (pad_reg != '0)
        begin
            pad_next = pad_reg - LINE_W'(1);
            if (final_byte)
            begin
                finished_next  = 1'b1;
                emit           = 1'b1;
                run.row_index  = row_reg[POS_W-1:0];
                run.image_done = 1'b1;
            end
        end
        else if (!pending_reg && data_byte >= RUN_HEADER_MIN)
        begin
            if (final_byte)
            begin
                // header with no value byte: drop the run, fill the row
                finished_next        = 1'b1;
                emit                 = 1'b1;
                run.start_column     = column_reg[POS_W-1:0];
                run.row_index        = row_reg[POS_W-1:0];
                run.zero_fill_count  = room;
                run.image_done       = 1'b1;
            end
            else
            begin
                pending_next = 1'b1;
                pcount_next  = CNT_W'(data_byte & RUN_COUNT_MASK);
            end
        end
        else
        begin
            pending_next = 1'b0;
            if (count != '0 && data_byte == ALPHA_INDEX)
                alpha_next = 1'b1;
            emit             = 1'b1;
            run.pixel_value  = data_byte;
            run.run_count    = count[CNT_W-1:0];
            run.start_column = column_reg[POS_W-1:0];
            run.row_index    = row_reg[POS_W-1:0];
            column_next      = new_column;
            if (new_column >= geom.width)
            begin
                column_next = '0;
                row_next    = next_row;
                pad_next    = (geom.line_bytes > LINE_W'(geom.width))
                            ? geom.line_bytes - LINE_W'(geom.width) : '0;
                if (next_row >= geom.height || final_byte)
                begin
                    run.image_done = 1'b1;
                    finished_next  = 1'b1;
                end
            end
            else if (final_byte)
            begin
                run.zero_fill_count = geom.width - new_column;
                run.image_done      = 1'b1;
                finished_next       = 1'b1;
            end
        end
        run.alpha_found = alpha_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg   <= '0;
            row_reg      <= '0;
            pending_reg  <= 1'b0;
            pcount_reg   <= '0;
            pad_reg      <= '0;
            alpha_reg    <= 1'b0;
            finished_reg <= 1'b0;
        end
        else if (step)
        begin
            column_reg   <= column_next;
            row_reg      <= row_next;
            pending_reg  <= pending_next;
            pcount_reg   <= pcount_next;
            pad_reg      <= pad_next;
            alpha_reg    <= alpha_next;
            finished_reg <= finished_next;
        end
    end

endmodule

>>> src/pcx_rle_row_decoder.sv
`timescale 1ns / 1ps
// Top level of the PCX 8-bit run-length row decoder.
//
// Takes one compressed byte per clock while each output word is taken at once,
// and gives one run word per value byte: a byte is latched in the input
// register, decoded by the step logic and its run word is registered in the
// output register. The sustained rate of one byte per cycle is set by the
// single step unit. A byte that yields a word waits in the input register
// only while the output word is held by the receiver. Run headers and padding
// bytes give no word unless they are the final byte, which gives a closing
// word; after the last row, or after the final byte, input bytes are taken
// and dropped until reset. Register writes are taken at any time but must
// only be made while the block is idle; they act at once.
module pcx_rle_row_decoder
    import pcxrle_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    pcxrle_in_if.sink    din,
    pcxrle_out_if.source dout,
    pcxrle_cfg_if.sink   cfg
);

    geom_t      geom;
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg, out_valid_next;
    run_t       out_run_reg;
    logic       emit;
    run_t       run;
    logic       out_free;
    logic       consume;

    // registers always take a write
    assign cfg.ready = 1'b1;

    pcxrle_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .geom     (geom)
    );

    pcxrle_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .geom       (geom),
        .step       (consume),
        .data_byte  (in_byte_reg),
        .final_byte (in_last_reg),
        .emit       (emit),
        .run        (run)
    );

    // Output slot is free when empty or being emptied this cycle; a byte that
    // yields no word never waits for it.
    assign out_free = !out_valid_reg || dout.ready;
    assign consume  = in_valid_reg && (!emit || out_free);
    assign din.ready = !in_valid_reg || consume;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (din.valid && din.ready)
            in_valid_next = 1'b1;
        else if (consume)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (consume && emit)
            out_valid_next = 1'b1;
        else if (dout.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: hold the byte until decoded, hold the word until taken.
    always_ff @(posedge clk)
    begin
        if (din.valid && din.ready)
        begin
            in_byte_reg <= din.data_byte;
            in_last_reg <= din.final_byte;
        end
        if (consume && emit)
            out_run_reg <= run;
    end

    assign dout.valid           = out_valid_reg;
    assign dout.pixel_value     = out_run_reg.pixel_value;
    assign dout.run_count       = out_run_reg.run_count;
    assign dout.start_column    = out_run_reg.start_column;
    assign dout.row_index       = out_run_reg.row_index;
    assign dout.zero_fill_count = out_run_reg.zero_fill_count;
    assign dout.alpha_found     = out_run_reg.alpha_found;
    assign dout.image_done      = out_run_reg.image_done;

endmodule

>>> src/pcxrle_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the PCX run-length row decoder, with its bind.
module pcxrle_checker
    import pcxrle_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [7:0]        pixel_value,
    input logic [CNT_W-1:0]  run_count,
    input logic [FILL_W-1:0] zero_fill_count,
    input logic              alpha_found,
    input logic              image_done
);

    logic out_take;
    logic alpha_seen_reg;

    assign out_take = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            alpha_seen_reg <= 1'b0;
        else if (out_take && alpha_found)
            alpha_seen_reg <= 1'b1;
    end

    // a stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_value)
                                    && $stable(run_count) && $stable(image_done))
        else $error("stalled run word changed");

    // nothing follows the word that closes the image
    assert property (@(posedge clk) disable iff (!rst_n)
        out_take && image_done |=> !out_valid)
        else $error("word after image end");

    // the alpha flag never falls once reported
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && alpha_seen_reg |-> alpha_found)
        else $error("alpha flag cleared");

    // a fill count only comes with the end of the data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_fill_count != '0 |-> image_done)
        else $error("zero fill without image end");

endmodule

bind pcx_rle_row_decoder pcxrle_checker u_pcxrle_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (dout.valid),
    .out_ready       (dout.ready),
    .pixel_value     (dout.pixel_value),
    .run_count       (dout.run_count),
    .zero_fill_count (dout.zero_fill_count),
    .alpha_found     (dout.alpha_found),
    .image_done      (dout.image_done)
);
